// ===== rtl/lwbc_pkg.sv =====
// Package: shared types, constants and command/status structs for the block cache.
package lwbc_pkg;

    localparam int NumBufs   = 16;
    localparam int SlotBits  = $clog2(NumBufs);
    localparam int CntBits   = SlotBits + 1;
    localparam int BlkBits   = 16;
    localparam int DataBits  = 64;

    // input kinds
    localparam logic [1:0] K_READ  = 2'd0;
    localparam logic [1:0] K_WRITE = 2'd1;
    localparam logic [1:0] K_SYNC  = 2'd2;
    localparam logic [1:0] K_FILL  = 2'd3;

    // result kinds
    localparam logic [2:0] R_READ_DATA  = 3'd0;
    localparam logic [2:0] R_WRITE_DONE = 3'd1;
    localparam logic [2:0] R_DISK_READ  = 3'd2;
    localparam logic [2:0] R_DISK_WRITE = 3'd3;
    localparam logic [2:0] R_SYNC_DONE  = 3'd4;
    localparam logic [2:0] R_REJECT     = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_EVICT_OUT,
        S_CLAIM,
        S_FINISH_OUT,
        S_SYNC_SCAN,
        S_SYNC_OUT,
        S_SYNC_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;        // latch the accepted item
        logic scan_clr;    // restart slot pointer
        logic scan_step;   // advance slot pointer
        logic claim;       // claim a slot (free or LRU victim)
        logic evict_clean; // clean victim, emit write-back
        logic finish;      // apply the item's final update, emit its result
        logic sync_emit;   // emit write-back for current dirty slot
        logic sync_next;   // advance sync order
        logic sync_done;   // clear dirty state, emit sync done
        logic out_load;    // output register takes a result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_end;    // pointer past last used slot
        logic found;       // lookup found the block
        logic full;        // no free slot
        logic victim_dirty;
        logic reject;      // latched item is rejected
        logic [1:0] kind;
        logic sync_hit;    // current slot has current dirty order
        logic sync_last_slot;
        logic sync_end;    // order reached dirty count
        logic out_busy;    // output register holds a result that is not taken this cycle
    } t_sts;

endpackage

// ===== rtl/lru_writeback_block_cache.sv =====
// Top level: fully associative LRU write-back block cache.
//
//  channel  direction  tdata (low bit up)                        tuser / tlast
//  s_axis   in         block_number[15:0], data[79:16]          kind[1:0] / -
//  m_axis   out        block_number_res[15:0], data_res[79:16]  kind_res[2:0], hit[3] / last
//
// One item at a time. Read/write: the item is latched, the lookup checks one slot
// per cycle and then the end check, a decide state, optional eviction and
// claim, then the result. Sync walks dirty order times slots, with a
// write-back for each dirty slot. Reset clears control state; no
// clearing pass. A stalled output holds the sequencer in its emit state.
module lru_writeback_block_cache (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // block_number[15:0], data[79:16]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // block_number_res[15:0], data_res[79:16]
    output logic [3:0]  m_axis_tuser,   // kind_res[2:0], hit[3]
    output logic        m_axis_tlast
);

    lwbc_pkg::t_cmd w_cmd;
    lwbc_pkg::t_sts w_sts;
    logic [2:0]  w_kind_res;
    logic [15:0] w_blk_res;
    logic [63:0] w_data_res;
    logic        w_hit;

    lwbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lwbc_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_kind             (s_axis_tuser),
        .i_block_number     (s_axis_tdata[15:0]),
        .i_data             (s_axis_tdata[79:16]),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .o_out_valid        (m_axis_tvalid),
        .i_out_ready        (m_axis_tready),
        .o_kind_res         (w_kind_res),
        .o_block_number_res (w_blk_res),
        .o_data_res         (w_data_res),
        .o_hit              (w_hit),
        .o_last             (m_axis_tlast)
    );

    assign m_axis_tdata = {w_data_res, w_blk_res};
    assign m_axis_tuser = {w_hit, w_kind_res};

endmodule

// ===== rtl/lwbc_ctrl.sv =====
// Controller: sequences lookup, eviction, sync walk and result issue.
module lwbc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lwbc_pkg::t_sts i_sts,
    output lwbc_pkg::t_cmd o_cmd
);

    lwbc_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lwbc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lwbc_pkg::S_IDLE: begin
                if (i_in_valid) n_state = lwbc_pkg::S_SCAN;
            end
            lwbc_pkg::S_SCAN: begin
                if (i_sts.reject || i_sts.kind == lwbc_pkg::K_FILL)
                    n_state = lwbc_pkg::S_FINISH_OUT;
                else if (i_sts.kind == lwbc_pkg::K_SYNC)
                    n_state = lwbc_pkg::S_SYNC_SCAN;
                else if (i_sts.found || i_sts.scan_end)
                    n_state = lwbc_pkg::S_DECIDE;
            end
            lwbc_pkg::S_DECIDE: begin
                if (i_sts.found)
                    n_state = lwbc_pkg::S_FINISH_OUT;
                else if (i_sts.full && i_sts.victim_dirty)
                    n_state = lwbc_pkg::S_EVICT_OUT;
                else
                    n_state = lwbc_pkg::S_CLAIM;
            end
            lwbc_pkg::S_EVICT_OUT: begin
                if (!i_sts.out_busy) n_state = lwbc_pkg::S_CLAIM;
            end
            lwbc_pkg::S_CLAIM: n_state = lwbc_pkg::S_FINISH_OUT;
            lwbc_pkg::S_FINISH_OUT: begin
                if (!i_sts.out_busy) n_state = lwbc_pkg::S_IDLE;
            end
            lwbc_pkg::S_SYNC_SCAN: begin
                if (i_sts.sync_end)
                    n_state = lwbc_pkg::S_SYNC_DONE;
                else if (i_sts.sync_hit)
                    n_state = lwbc_pkg::S_SYNC_OUT;
            end
            lwbc_pkg::S_SYNC_OUT: begin
                if (!i_sts.out_busy) n_state = lwbc_pkg::S_SYNC_SCAN;
            end
            lwbc_pkg::S_SYNC_DONE: begin
                if (!i_sts.out_busy) n_state = lwbc_pkg::S_IDLE;
            end
            default: n_state = lwbc_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            lwbc_pkg::S_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.load       = i_in_valid;
                o_cmd.scan_clr   = 1'b1;
            end
            lwbc_pkg::S_SCAN: begin
                if (!(i_sts.found || i_sts.scan_end)) o_cmd.scan_step = 1'b1;
                if (i_sts.kind == lwbc_pkg::K_SYNC) o_cmd.scan_clr = 1'b1;
            end
            lwbc_pkg::S_DECIDE: ;
            lwbc_pkg::S_EVICT_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.evict_clean = 1'b1;
                    o_cmd.out_load    = 1'b1;
                end
            end
            lwbc_pkg::S_CLAIM: o_cmd.claim = 1'b1;
            lwbc_pkg::S_FINISH_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish   = 1'b1;
                    o_cmd.out_load = 1'b1;
                end
            end
            lwbc_pkg::S_SYNC_SCAN: begin
                if (!i_sts.sync_end && !i_sts.sync_hit) begin
                    o_cmd.scan_step = 1'b1;
                    if (i_sts.sync_last_slot) o_cmd.sync_next = 1'b1;
                end
            end
            lwbc_pkg::S_SYNC_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.sync_emit = 1'b1;
                    o_cmd.sync_next = 1'b1;
                    o_cmd.scan_clr  = 1'b1;
                    o_cmd.out_load  = 1'b1;
                end
            end
            lwbc_pkg::S_SYNC_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.sync_done = 1'b1;
                    o_cmd.out_load  = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/lwbc_dp.sv =====
// Datapath: slot stores, recency and dirty-order state, result register.
module lwbc_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [1:0]                    i_kind,
    input  logic [lwbc_pkg::BlkBits-1:0]  i_block_number,
    input  logic [lwbc_pkg::DataBits-1:0] i_data,
    input  lwbc_pkg::t_cmd                i_cmd,
    output lwbc_pkg::t_sts                o_sts,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [2:0]                    o_kind_res,
    output logic [lwbc_pkg::BlkBits-1:0]  o_block_number_res,
    output logic [lwbc_pkg::DataBits-1:0] o_data_res,
    output logic                          o_hit,
    output logic                          o_last
);

    localparam int SB = lwbc_pkg::SlotBits;
    localparam int CB = lwbc_pkg::CntBits;
    localparam int NB = lwbc_pkg::NumBufs;

    // slot stores (block read at pointer and LRU slot; data also at the latched slot)
    logic [lwbc_pkg::BlkBits-1:0]  r_blk_mem  [NB];
    logic [lwbc_pkg::DataBits-1:0] r_data_mem [NB];
    logic [SB-1:0]                 r_rank     [NB];
    logic [CB-1:0]                 r_dorder   [NB];
    logic [NB-1:0]                 r_dirty;

    logic [CB-1:0] r_used, r_ndirty, r_ptr, r_sorder;
    logic          r_pending;
    logic [lwbc_pkg::BlkBits-1:0] r_pend_blk;
    logic [SB-1:0] r_pend_slot;

    // latched item and lookup result
    logic [1:0]                    r_kind;
    logic [lwbc_pkg::BlkBits-1:0]  r_blk;
    logic [lwbc_pkg::DataBits-1:0] r_data;
    logic                          r_found;
    logic [SB-1:0]                 r_slot;

    logic                          r_ovalid;

    logic [SB-1:0] w_ptr;
    logic [SB-1:0] w_lru;
    logic          w_reject;

    assign w_ptr    = r_ptr[SB-1:0];
    assign w_reject = (r_kind == lwbc_pkg::K_FILL) ? !r_pending : r_pending;

    // LRU slot: rank zero (independent compares over slots)
    always_comb begin
        w_lru = '0;
        for (int i = NB - 1; i >= 0; i--) begin
            if (r_rank[i] == '0) w_lru = SB'(i);
        end
    end

    // status
    always_comb begin
        o_sts                = '0;
        o_sts.kind           = r_kind;
        o_sts.reject         = w_reject;
        o_sts.scan_end       = (r_ptr >= r_used);
        o_sts.found          = r_found;
        o_sts.full           = (r_used == CB'(NB));
        o_sts.victim_dirty   = r_dirty[w_lru];
        o_sts.sync_end       = (r_sorder >= r_ndirty);
        o_sts.sync_hit       = r_dirty[w_ptr] && (r_dorder[w_ptr] == r_sorder);
        o_sts.sync_last_slot = (r_ptr == CB'(NB - 1));
        o_sts.out_busy       = r_ovalid && !i_out_ready;
    end

    // item latch, lookup pointer, lookup hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_found  <= 1'b0;
            r_sorder <= '0;
        end else begin
            if (i_cmd.load) begin
                r_kind <= i_kind;
                r_blk  <= i_block_number;
                r_data <= i_data;
            end
            if (i_cmd.scan_clr) begin
                r_ptr   <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (r_kind != lwbc_pkg::K_SYNC && r_blk_mem[w_ptr] == r_blk) begin
                    r_found <= 1'b1;
                    r_slot  <= w_ptr;
                end else begin
                    r_ptr <= (r_ptr == CB'(NB - 1) && r_kind == lwbc_pkg::K_SYNC)
                             ? '0 : r_ptr + 1'b1;
                end
            end
            if (i_cmd.load) r_sorder <= '0;
            else if (i_cmd.sync_next) r_sorder <= r_sorder + 1'b1;
            if (i_cmd.claim) r_slot <= o_sts.full ? w_lru : r_used[SB-1:0];
        end
    end

    // slot state updates and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty     <= '0;
            r_ndirty    <= '0;
            r_used      <= '0;
            r_pending   <= 1'b0;
            r_pend_blk  <= '0;
            r_pend_slot <= '0;
            r_ovalid    <= 1'b0;
            for (int i = 0; i < NB; i++) r_dorder[i] <= '0;
        end else begin
            // result held until taken, refilled on a load
            r_ovalid <= i_cmd.out_load | (r_ovalid & ~i_out_ready);

            // victim write-back and clean
            if (i_cmd.evict_clean) begin
                o_kind_res         <= lwbc_pkg::R_DISK_WRITE;
                o_block_number_res <= r_blk_mem[w_lru];
                o_data_res         <= r_data_mem[w_lru];
                o_hit              <= 1'b0;
                o_last             <= 1'b0;
                for (int i = 0; i < NB; i++) begin
                    if (r_dirty[i] && r_dorder[i] > r_dorder[w_lru])
                        r_dorder[i] <= r_dorder[i] - 1'b1;
                end
                r_dirty[w_lru]  <= 1'b0;
                r_dorder[w_lru] <= '0;
                r_ndirty        <= r_ndirty - 1'b1;
            end

            // claim: fill a free slot or reuse the LRU one
            if (i_cmd.claim) begin
                if (o_sts.full) begin
                    for (int i = 0; i < NB; i++) begin
                        if (SB'(i) == w_lru) r_rank[i] <= SB'(NB - 1);
                        else r_rank[i] <= r_rank[i] - 1'b1;
                    end
                    r_blk_mem[w_lru] <= r_blk;
                end else begin
                    r_rank[r_used[SB-1:0]]    <= r_used[SB-1:0];
                    r_blk_mem[r_used[SB-1:0]] <= r_blk;
                    r_used                    <= r_used + 1'b1;
                end
            end

            // final update of read, write, fill or rejected item
            if (i_cmd.finish) begin
                o_last             <= 1'b1;
                o_hit              <= 1'b0;
                o_block_number_res <= r_blk;
                o_data_res         <= '0;
                if (w_reject) begin
                    o_kind_res <= lwbc_pkg::R_REJECT;
                end else if (r_kind == lwbc_pkg::K_FILL) begin
                    o_kind_res              <= lwbc_pkg::R_READ_DATA;
                    o_block_number_res      <= r_pend_blk;
                    o_data_res              <= r_data;
                    r_data_mem[r_pend_slot] <= r_data;
                    r_pending               <= 1'b0;
                end else begin
                    // hit: move slot to most recent
                    if (r_found) begin
                        o_hit <= 1'b1;
                        for (int i = 0; i < NB; i++) begin
                            if (CB'(i) < r_used && SB'(i) != r_slot
                                && r_rank[i] > r_rank[r_slot])
                                r_rank[i] <= r_rank[i] - 1'b1;
                        end
                        r_rank[r_slot] <= SB'(r_used - 1'b1);
                    end
                    if (r_kind == lwbc_pkg::K_READ) begin
                        if (r_found) begin
                            o_kind_res <= lwbc_pkg::R_READ_DATA;
                            o_data_res <= r_data_mem[r_slot];
                        end else begin
                            o_kind_res  <= lwbc_pkg::R_DISK_READ;
                            r_pending   <= 1'b1;
                            r_pend_blk  <= r_blk;
                            r_pend_slot <= r_slot;
                        end
                    end else begin
                        o_kind_res         <= lwbc_pkg::R_WRITE_DONE;
                        r_data_mem[r_slot] <= r_data;
                        if (!r_dirty[r_slot]) begin
                            r_dirty[r_slot]  <= 1'b1;
                            r_dorder[r_slot] <= r_ndirty;
                            r_ndirty         <= r_ndirty + 1'b1;
                        end
                    end
                end
            end

            // sync write-back of one slot
            if (i_cmd.sync_emit) begin
                o_kind_res         <= lwbc_pkg::R_DISK_WRITE;
                o_block_number_res <= r_blk_mem[w_ptr];
                o_data_res         <= r_data_mem[w_ptr];
                o_hit              <= 1'b0;
                o_last             <= 1'b0;
            end

            if (i_cmd.sync_done) begin
                o_kind_res         <= lwbc_pkg::R_SYNC_DONE;
                o_block_number_res <= '0;
                o_data_res         <= '0;
                o_hit              <= 1'b0;
                o_last             <= 1'b1;
                r_dirty            <= '0;
                r_ndirty           <= '0;
                for (int i = 0; i < NB; i++) r_dorder[i] <= '0;
            end
        end
    end

    assign o_out_valid = r_ovalid;

endmodule
